/* rtl/round_robin_tick_scheduler_assert.svh */
// assertion macros used by the checker file rrts_checker.sv
`ifndef ROUND_ROBIN_TICK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_ASSERT_SVH

// same-cycle implication on clk, gated by rst_n
`define RRTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts assertion failed");

// next-cycle implication on clk, gated by rst_n
`define RRTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts assertion failed");

`endif

/* rtl/rrts_pkg.sv */
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NEED_BITS_DEF   = 16;
    localparam int ID_W            = 8;
    localparam int QUANTUM_W       = 8;
    localparam int SLICE_W         = 8;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd2;

    typedef enum logic
    {
        OP_ADMIT = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

/* rtl/rrts_if.sv */
`timescale 1ns / 1ps

interface rrts_cmd_if #(
    parameter int NEED_BITS = rrts_pkg::NEED_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [rrts_pkg::ID_W-1:0] task_id;
    logic [NEED_BITS-1:0]      need_slices;

    modport source (output valid, opcode, task_id, need_slices, input ready);
    modport sink   (input valid, opcode, task_id, need_slices, output ready);
endinterface

interface rrts_rsp_if #(
    parameter int NEED_BITS = rrts_pkg::NEED_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic                      ran_valid;
    logic [rrts_pkg::ID_W-1:0] ran_id;
    logic [NEED_BITS-1:0]      ran_left;
    logic                      finished;
    logic                      preempted;
    logic                      now_valid;
    logic [rrts_pkg::ID_W-1:0] now_id;

    modport source (output valid, accepted, ran_valid, ran_id, ran_left, finished,
                    preempted, now_valid, now_id, input ready);
    modport sink   (input valid, accepted, ran_valid, ran_id, ran_left, finished,
                    preempted, now_valid, now_id, output ready);
endinterface

/* rtl/rrts_ctrl.sv */
`timescale 1ns / 1ps

module rrts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rrts_pkg::ctrl_cmd_t ctrl
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_SEND);
    assign ctrl.load = cmd_valid && (state_reg == ST_IDLE);
    assign ctrl.exec = (state_reg == ST_EXEC);

endmodule

/* rtl/rrts_dp.sv */
`timescale 1ns / 1ps

module rrts_dp #(
    parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF,
    parameter int NEED_BITS   = rrts_pkg::NEED_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rrts_pkg::ctrl_cmd_t            ctrl,
    input  logic                           cfg_we,
    input  logic [rrts_pkg::QUANTUM_W-1:0] cfg_wdata,
    input  logic                           opcode,
    input  logic [rrts_pkg::ID_W-1:0]      task_id,
    input  logic [NEED_BITS-1:0]           need_slices,
    output logic                           accepted,
    output logic                           ran_valid,
    output logic [rrts_pkg::ID_W-1:0]      ran_id,
    output logic [NEED_BITS-1:0]           ran_left,
    output logic                           finished,
    output logic                           preempted,
    output logic                           now_valid,
    output logic [rrts_pkg::ID_W-1:0]      now_id
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W  = rrts_pkg::ID_W;
    localparam int Q_W   = rrts_pkg::QUANTUM_W;
    localparam int S_W   = rrts_pkg::SLICE_W;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // ready queue storage
    logic [ID_W-1:0]      ids_mem   [QUEUE_DEPTH];
    logic [NEED_BITS-1:0] needs_mem [QUEUE_DEPTH];

    logic [ID_W-1:0]      head_id_reg;
    logic [NEED_BITS-1:0] head_need_reg;

    logic                 op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [NEED_BITS-1:0] need_reg;

    logic [Q_W-1:0]       quantum_reg;

    logic [PTR_W-1:0]     head_ptr_reg,  head_ptr_next;
    logic [PTR_W-1:0]     tail_ptr_reg,  tail_ptr_next;
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic                 run_valid_reg, run_valid_next;
    logic [ID_W-1:0]      run_id_reg,    run_id_next;
    logic [NEED_BITS-1:0] run_need_reg,  run_need_next;
    logic [S_W-1:0]       slice_reg,     slice_next;

    logic                 accepted_reg,  accepted_next;
    logic                 ran_valid_reg, ran_valid_next;
    logic [ID_W-1:0]      ran_id_reg,    ran_id_next;
    logic [NEED_BITS-1:0] ran_left_reg,  ran_left_next;
    logic                 finished_reg,  finished_next;
    logic                 preempted_reg, preempted_next;
    logic                 now_valid_reg, now_valid_next;
    logic [ID_W-1:0]      now_id_reg,    now_id_next;

    logic                 push_en;
    logic [ID_W-1:0]      push_id;
    logic [NEED_BITS-1:0] push_need;
    logic [Q_W-1:0]       q_eff;
    logic [NEED_BITS-1:0] need_dec;
    logic [S_W-1:0]       slice_inc;
    logic                 queue_empty;

    always_comb
    begin
        head_ptr_next  = head_ptr_reg;
        tail_ptr_next  = tail_ptr_reg;
        count_next     = count_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_need_next  = run_need_reg;
        slice_next     = slice_reg;
        push_en        = 1'b0;
        push_id        = id_reg;
        push_need      = need_reg;
        accepted_next  = 1'b0;
        ran_valid_next = 1'b0;
        ran_id_next    = '0;
        ran_left_next  = '0;
        finished_next  = 1'b0;
        preempted_next = 1'b0;
        q_eff          = (quantum_reg == '0) ? Q_W'(1) : quantum_reg;
        need_dec       = run_need_reg - NEED_BITS'(1);
        slice_inc      = slice_reg + S_W'(1);
        queue_empty    = (count_reg == '0);

        if (op_reg == rrts_pkg::OP_ADMIT)
        begin
            if (need_reg != '0)
            begin
                if (!run_valid_reg)
                begin
                    run_valid_next = 1'b1;
                    run_id_next    = id_reg;
                    run_need_next  = need_reg;
                    slice_next     = '0;
                    accepted_next  = 1'b1;
                end
                else if (count_reg != CNT_W'(QUEUE_DEPTH))
                begin
                    push_en       = 1'b1;
                    tail_ptr_next = next_slot(tail_ptr_reg);
                    count_next    = count_reg + CNT_W'(1);
                    accepted_next = 1'b1;
                end
            end
        end
        else if (run_valid_reg)
        begin
            ran_valid_next = 1'b1;
            ran_id_next    = run_id_reg;
            ran_left_next  = need_dec;
            if (need_dec == '0)
            begin
                finished_next = 1'b1;
                slice_next    = '0;
                if (queue_empty)
                begin
                    run_valid_next = 1'b0;
                    run_id_next    = '0;
                    run_need_next  = '0;
                end
                else
                begin
                    run_id_next   = head_id_reg;
                    run_need_next = head_need_reg;
                    head_ptr_next = next_slot(head_ptr_reg);
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            else if (slice_inc >= q_eff)
            begin
                preempted_next = 1'b1;
                slice_next     = '0;
                if (queue_empty)
                begin
                    run_need_next = need_dec;
                end
                else
                begin
                    // pop head, then push the preempted task at the tail
                    run_id_next   = head_id_reg;
                    run_need_next = head_need_reg;
                    head_ptr_next = next_slot(head_ptr_reg);
                    tail_ptr_next = next_slot(tail_ptr_reg);
                    push_en       = 1'b1;
                    push_id       = run_id_reg;
                    push_need     = need_dec;
                end
            end
            else
            begin
                run_need_next = need_dec;
                slice_next    = slice_inc;
            end
        end

        now_valid_next = run_valid_next;
        now_id_next    = run_valid_next ? run_id_next : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec && push_en)
        begin
            ids_mem[tail_ptr_reg]   <= push_id;
            needs_mem[tail_ptr_reg] <= push_need;
        end
        head_id_reg   <= ids_mem[head_ptr_reg];
        head_need_reg <= needs_mem[head_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg   <= opcode;
            id_reg   <= task_id;
            need_reg <= need_slices;
        end
        if (ctrl.exec)
        begin
            accepted_reg  <= accepted_next;
            ran_valid_reg <= ran_valid_next;
            ran_id_reg    <= ran_id_next;
            ran_left_reg  <= ran_left_next;
            finished_reg  <= finished_next;
            preempted_reg <= preempted_next;
            now_valid_reg <= now_valid_next;
            now_id_reg    <= now_id_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= rrts_pkg::QUANTUM_RESET;
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_need_reg  <= '0;
            slice_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
            if (ctrl.exec)
            begin
                head_ptr_reg  <= head_ptr_next;
                tail_ptr_reg  <= tail_ptr_next;
                count_reg     <= count_next;
                run_valid_reg <= run_valid_next;
                run_id_reg    <= run_id_next;
                run_need_reg  <= run_need_next;
                slice_reg     <= slice_next;
            end
        end
    end

    assign accepted  = accepted_reg;
    assign ran_valid = ran_valid_reg;
    assign ran_id    = ran_id_reg;
    assign ran_left  = ran_left_reg;
    assign finished  = finished_reg;
    assign preempted = preempted_reg;
    assign now_valid = now_valid_reg;
    assign now_id    = now_id_reg;

endmodule

/* rtl/round_robin_tick_scheduler.sv */
`timescale 1ns / 1ps
// Round-robin time-slice scheduler.
// cmd channel: one word per item, opcode 0 admits task_id with need_slices,
// opcode 1 charges one slice to the running task.
// rsp channel: exactly one word per cmd word, in order, reporting whether an
// admit was taken, which task ran on a tick, its remaining need, finish or
// preemption, and the task running afterward.
// cfg_we / cfg_wdata write the quantum (0 acts as 1); write only while idle.
// After a cmd word is taken the result is registered in ST_EXEC and the
// rsp word is presented in ST_SEND; the queue head is read from a
// registered-read memory port, so an item is taken only once the previous
// response has left and the head read has settled.
// A stalled rsp holds its word and cmd.ready stays low until it is taken.
// Reset empties the queue, leaves no task running and sets the quantum to 2;
// queue storage is not cleared and needs no clearing pass.
module round_robin_tick_scheduler #(
    parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF,
    parameter int NEED_BITS   = rrts_pkg::NEED_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rrts_pkg::QUANTUM_W-1:0] cfg_wdata,
    rrts_cmd_if.sink                       cmd,
    rrts_rsp_if.source                     rsp
);

    rrts_pkg::ctrl_cmd_t ctrl;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    rrts_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NEED_BITS   (NEED_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .opcode      (cmd.opcode),
        .task_id     (cmd.task_id),
        .need_slices (cmd.need_slices),
        .accepted    (rsp.accepted),
        .ran_valid   (rsp.ran_valid),
        .ran_id      (rsp.ran_id),
        .ran_left    (rsp.ran_left),
        .finished    (rsp.finished),
        .preempted   (rsp.preempted),
        .now_valid   (rsp.now_valid),
        .now_id      (rsp.now_id)
    );

endmodule

/* rtl/rrts_checker.sv */
`timescale 1ns / 1ps
`include "round_robin_tick_scheduler_assert.svh"

module rrts_checker #(
    parameter int NEED_BITS = rrts_pkg::NEED_BITS_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic                      accepted,
    input logic                      ran_valid,
    input logic [NEED_BITS-1:0]      ran_left,
    input logic                      finished,
    input logic                      preempted,
    input logic                      now_valid,
    input logic [rrts_pkg::ID_W-1:0] now_id
);

    `RRTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    `RRTS_ASSERT_NOW(a_admit_no_run, rsp_valid && accepted, !ran_valid)

    `RRTS_ASSERT_NOW(a_fin_zero, rsp_valid && finished, ran_valid && ran_left == '0 && !preempted)

    `RRTS_ASSERT_NOW(a_pre_left, rsp_valid && preempted, ran_valid && ran_left != '0 && now_valid)

    `RRTS_ASSERT_NOW(a_idle_id, rsp_valid && !now_valid, now_id == '0)

endmodule

bind round_robin_tick_scheduler rrts_checker #(
    .NEED_BITS (NEED_BITS)
) u_rrts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .accepted  (rsp.accepted),
    .ran_valid (rsp.ran_valid),
    .ran_left  (rsp.ran_left),
    .finished  (rsp.finished),
    .preempted (rsp.preempted),
    .now_valid (rsp.now_valid),
    .now_id    (rsp.now_id)
);
